>>> sv/veto_edge_coincidence_trigger_unit_defines.svh
// Assertion macros shared by the trigger unit.
`ifndef VETO_EDGE_COINCIDENCE_TRIGGER_UNIT_DEFINES_SVH
`define VETO_EDGE_COINCIDENCE_TRIGGER_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define VECT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define VECT_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> sv/vect_pkg.sv
package vect_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_EVENT_START = 2'd0,
		KIND_BOARD_START = 2'd1,
		KIND_EDGE        = 2'd2,
		KIND_EVENT_END   = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] REG_REF_SOURCE    = 2'd0;
	localparam logic [1:0] REG_WINDOW_TICKS  = 2'd1;
	localparam logic [1:0] REG_HIT_THRESHOLD = 2'd2;

	// Reference time sources
	localparam logic [1:0] REF_SRC_L0   = 2'd0;
	localparam logic [1:0] REF_SRC_CHOD = 2'd1;

	localparam logic [1:0]  REF_SOURCE_RESET    = REF_SRC_L0;
	localparam logic [15:0] WINDOW_TICKS_RESET  = 16'd103;
	localparam logic [3:0]  HIT_THRESHOLD_RESET = 4'd3;

	localparam int CHANNELS_DEFAULT = 512;
	localparam int CHANNEL_W        = 9;
	localparam int EPOCH_W          = 10;
	localparam int IN_DATA_W        = 120;
	localparam int OUT_DATA_W       = 8;
	localparam int REF_W            = 42;
	localparam int DIFF_W           = 43;

	// One result item, first field in the highest bit
	typedef struct packed {
		logic       empty_packet;
		logic       bad_data;
		logic       processed;
		logic [3:0] hit_count;
		logic       trigger;
	} result_t;

endpackage

>>> sv/veto_edge_coincidence_trigger_unit.sv
// A result is registered twice after the transaction that causes it: the flag memory
// is read into stage 1, then the item is evaluated into the output register.
// Throughput: one item per cycle unless the sink or a sweep stalls; flag writes are forwarded.
// Flags are cleared by bumping an epoch tag; every 2^EPOCH_W-1 clears, and once after
// reset, a clearing pass sweeps every memory entry and holds s_axis_tready low.
// Reset (arst_n, asynchronous, active low): event open, reference zero, register defaults.
`include "veto_edge_coincidence_trigger_unit_defines.svh"

module veto_edge_coincidence_trigger_unit #(
	parameter int CHANNELS = vect_pkg::CHANNELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// from bit 0: event_timestamp[31:0], fine_time[39:32], chod_valid[40],
	// chod_ref_ticks[64:41], board_skip[65], board_bad[66], edge_time[106:67],
	// channel[115:107], is_leading[116], zero fill[119:117]
	input  logic [vect_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// from bit 0: kind[1:0]
	input  logic [1:0]                      s_axis_tuser,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// from bit 0: trigger[0], hit_count[4:1], processed[5], bad_data[6], empty_packet[7]
	output logic [vect_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [15:0]                     cfg_data
);

	localparam int AW = $clog2(CHANNELS);
	localparam int RANGE_W = vect_pkg::CHANNEL_W + 2;
	localparam int EW = vect_pkg::EPOCH_W;

	// ------------------------------------------------------------------
	// Configuration registers: always ready; write them only while no
	// item is in flight.
	// ------------------------------------------------------------------
	logic [1:0]  ref_source_q;
	logic [15:0] window_ticks_q;
	logic [3:0]  hit_threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_source_q    <= vect_pkg::REF_SOURCE_RESET;
			window_ticks_q  <= vect_pkg::WINDOW_TICKS_RESET;
			hit_threshold_q <= vect_pkg::HIT_THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				vect_pkg::REG_REF_SOURCE:    ref_source_q    <= cfg_data[1:0];
				vect_pkg::REG_WINDOW_TICKS:  window_ticks_q  <= cfg_data;
				vect_pkg::REG_HIT_THRESHOLD: hit_threshold_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input field unpacking
	// ------------------------------------------------------------------
	logic [31:0] in_ts;
	logic [7:0]  in_fine;
	logic        in_chod_valid;
	logic [23:0] in_chod;
	logic        in_skip;
	logic        in_bad;
	logic [39:0] in_edge_time;
	logic [8:0]  in_channel;
	logic        in_lead;

	assign in_ts         = s_axis_tdata[31:0];
	assign in_fine       = s_axis_tdata[39:32];
	assign in_chod_valid = s_axis_tdata[40];
	assign in_chod       = s_axis_tdata[64:41];
	assign in_skip       = s_axis_tdata[65];
	assign in_bad        = s_axis_tdata[66];
	assign in_edge_time  = s_axis_tdata[106:67];
	assign in_channel    = s_axis_tdata[115:107];
	assign in_lead       = s_axis_tdata[116];

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic in_accept;
	logic s1_adv;
	logic valid_s1;
	logic sweep_q;
	logic out_valid_q;

	assign s1_adv        = valid_s1 && !sweep_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !sweep_q && (!valid_s1 || s1_adv);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Stage 1 payload: the item whose flag tag has been read into rd_tag_s1
	vect_pkg::kind_t kind_s1;
	logic [31:0]     ts_s1;
	logic [7:0]      fine_s1;
	logic            chod_valid_s1;
	logic [23:0]     chod_s1;
	logic            skip_s1;
	logic            bad_s1;
	logic [39:0]     edge_time_s1;
	logic [8:0]      channel_s1;
	logic            lead_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1       <= vect_pkg::kind_t'(s_axis_tuser);
			ts_s1         <= in_ts;
			fine_s1       <= in_fine;
			chod_valid_s1 <= in_chod_valid;
			chod_s1       <= in_chod;
			skip_s1       <= in_skip;
			bad_s1        <= in_bad;
			edge_time_s1  <= in_edge_time;
			channel_s1    <= in_channel;
			lead_s1       <= in_lead;
		end
	end

	// ------------------------------------------------------------------
	// Flag memory: one epoch tag per channel. A flag is set when its tag
	// equals the current epoch; a clear advances the epoch, or on wrap starts a clearing pass.
	// ------------------------------------------------------------------
	logic [EW-1:0] tag_mem [CHANNELS];
	logic [EW-1:0] rd_tag_s1;
	logic [EW-1:0] epoch_q;
	logic [AW-1:0] sweep_cnt_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] addr_s1;
	logic          mem_we;
	logic          flag_clear;
	logic          clear_wrap;
	logic          stale_q;
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [EW-1:0] wr_tag_q;

	assign rd_addr    = AW'(in_channel);
	assign addr_s1    = AW'(channel_s1);
	assign clear_wrap = s1_adv && flag_clear && (epoch_q == {EW{1'b1}});

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			tag_mem[sweep_cnt_q] <= '0;
		end else if (s1_adv && mem_we) begin
			tag_mem[addr_s1] <= epoch_q;
		end
		if (in_accept) begin
			rd_tag_s1 <= tag_mem[rd_addr];
		end
	end

	// Epoch and clearing pass; tag zero is never a live epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= EW'(1);
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else begin
			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + AW'(1);
				if (sweep_cnt_q == AW'(CHANNELS - 1)) begin
					sweep_q <= 1'b0;
				end
			end
			if (clear_wrap) begin
				epoch_q     <= EW'(1);
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end else if (s1_adv && flag_clear) begin
				epoch_q <= epoch_q + EW'(1);
			end
		end
	end

	// Forward the last write over a read that was issued on the same edge;
	// drop the read entirely when a clearing pass starts on that edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q    <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			if (clear_wrap) begin
				stale_q <= 1'b1;
			end else if (in_accept) begin
				stale_q <= 1'b0;
			end
			if (clear_wrap) begin
				wr_valid_q <= 1'b0;
			end else if (s1_adv) begin
				wr_valid_q <= mem_we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && mem_we) begin
			wr_addr_q <= addr_s1;
			wr_tag_q  <= epoch_q;
		end
	end

	logic flag_s1;
	assign flag_s1 = !stale_q && ((rd_tag_s1 == epoch_q) ||
		(wr_valid_q && (wr_addr_q == addr_s1) && (wr_tag_q == epoch_q)));

	// ------------------------------------------------------------------
	// Event state and stage 1 evaluation
	// ------------------------------------------------------------------
	logic                          event_closed_q;
	logic                          board_seen_q;
	logic                          board_skipping_q;
	logic                          edge_nz_q;
	logic [3:0]                    hits_q;
	logic signed [vect_pkg::REF_W-1:0] ref_q;

	logic                          event_closed_d;
	logic                          board_seen_d;
	logic                          board_skipping_d;
	logic                          edge_nz_d;
	logic [3:0]                    hits_d;
	logic [3:0]                    hits_inc;
	logic signed [vect_pkg::REF_W-1:0] ref_d;
	logic signed [vect_pkg::REF_W-1:0] base_ref;
	logic signed [vect_pkg::DIFF_W-1:0] diff;
	logic signed [vect_pkg::DIFF_W-1:0] win;
	logic                          in_window;
	logic                          ch_ok;
	logic                          out_load;
	vect_pkg::result_t             result;

	assign base_ref  = $signed({2'b00, ts_s1, 8'h00});
	assign diff      = $signed({3'b000, edge_time_s1}) - vect_pkg::DIFF_W'(ref_q);
	assign win       = $signed({27'd0, window_ticks_q});
	assign in_window = (diff < win) && (diff > -win);
	assign ch_ok     = !channel_s1[0] &&
		({2'b00, channel_s1} < RANGE_W'(CHANNELS));
	assign hits_inc  = hits_q + 4'd1;

	always_comb begin
		event_closed_d   = event_closed_q;
		board_seen_d     = board_seen_q;
		board_skipping_d = board_skipping_q;
		edge_nz_d        = edge_nz_q;
		hits_d           = hits_q;
		ref_d            = ref_q;
		flag_clear       = 1'b0;
		mem_we           = 1'b0;
		out_load         = 1'b0;
		result           = '0;
		case (kind_s1)
			vect_pkg::KIND_EVENT_START: begin
				if (ref_source_q == vect_pkg::REF_SRC_L0) begin
					ref_d = base_ref + $signed({34'd0, fine_s1});
				end else if (ref_source_q == vect_pkg::REF_SRC_CHOD && chod_valid_s1) begin
					ref_d = base_ref + vect_pkg::REF_W'($signed(chod_s1));
				end else begin
					ref_d = base_ref;
				end
				flag_clear       = 1'b1;
				hits_d           = '0;
				edge_nz_d        = 1'b0;
				board_seen_d     = 1'b0;
				board_skipping_d = 1'b0;
				event_closed_d   = 1'b0;
			end
			vect_pkg::KIND_BOARD_START: begin
				if (!event_closed_q) begin
					board_seen_d = 1'b1;
					if (skip_s1) begin
						board_skipping_d = 1'b1;
					end else if (bad_s1) begin
						event_closed_d  = 1'b1;
						out_load        = 1'b1;
						result.bad_data = 1'b1;
					end else begin
						board_skipping_d = 1'b0;
						flag_clear       = 1'b1;
					end
				end
			end
			vect_pkg::KIND_EDGE: begin
				if (!event_closed_q && board_seen_q && !board_skipping_q) begin
					edge_nz_d = 1'b1;
					if (ch_ok) begin
						if (lead_s1) begin
							mem_we = in_window;
						end else if (flag_s1) begin
							hits_d = hits_inc;
							if (hits_inc >= hit_threshold_q) begin
								event_closed_d   = 1'b1;
								out_load         = 1'b1;
								result.trigger   = 1'b1;
								result.hit_count = hits_inc;
								result.processed = 1'b1;
							end
						end
					end
				end
			end
			vect_pkg::KIND_EVENT_END: begin
				if (!event_closed_q) begin
					event_closed_d = 1'b1;
					out_load       = 1'b1;
					if (!board_seen_q) begin
						result.bad_data = 1'b1;
					end else begin
						result.trigger      = (hits_q >= hit_threshold_q);
						result.hit_count    = hits_q;
						result.processed    = 1'b1;
						result.empty_packet = !edge_nz_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_closed_q   <= 1'b0;
			board_seen_q     <= 1'b0;
			board_skipping_q <= 1'b0;
			edge_nz_q        <= 1'b0;
			hits_q           <= '0;
			ref_q            <= '0;
		end else if (s1_adv) begin
			event_closed_q   <= event_closed_d;
			board_seen_q     <= board_seen_d;
			board_skipping_q <= board_skipping_d;
			edge_nz_q        <= edge_nz_d;
			hits_q           <= hits_d;
			ref_q            <= ref_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds a result while the sink stalls
	// ------------------------------------------------------------------
	vect_pkg::result_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && out_load) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`VECT_ASSERT(a_epoch_live, epoch_q != '0, "epoch tag reached the swept value")
	`VECT_ASSERT(a_no_write_in_sweep, !(sweep_q && s1_adv), "item evaluated during sweep")
	`VECT_ASSERT(a_result_open_event, !(s1_adv && out_load && event_closed_q),
		"result produced by a closed event")
	`VECT_ASSERT_NEXT(a_wrap_sweeps, clear_wrap, sweep_q && stale_q && (epoch_q == EW'(1)),
		"epoch wrap did not start a clearing pass")

endmodule
